// File: sv/uhi_pkg.sv
// shared types, constants and helper functions of the upper hull perimeter block
package uhi_pkg;

    localparam int CAPACITY   = 1024;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int BASE_W  = 16;
    localparam int LEN_W   = 34;
    localparam int STAT_W  = 3;
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 2);
    localparam int ENTRY_W = 2 * COORD_BITS;
    localparam int DIFF_W  = COORD_BITS + 2;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int SQ_W    = 2 * COORD_BITS + 1;
    localparam int ITER    = COORD_BITS + FRAC_BITS + 2;
    localparam int ITER_W  = $clog2(ITER + 1);

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [CROSS_W-1:0]  t_cross;
    typedef logic [LEN_W-1:0]           t_len;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [ENTRY_W-1:0]         t_entry;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    typedef enum logic [STAT_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_INSIDE  = 3'd1,
        ST_IGNORED = 3'd2,
        ST_FULL    = 3'd3,
        ST_QUERY   = 3'd4
    } t_status;

    function automatic t_diff diff(input t_coord a, input t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

    function automatic t_coord base_eff(input logic [BASE_W-1:0] b);
        t_coord c;
        c = t_coord'(b);
        return (c < t_coord'(2)) ? t_coord'(2) : c;
    endfunction

    function automatic t_len base_len(input logic [BASE_W-1:0] b);
        return t_len'(base_eff(b)) << FRAC_BITS;
    endfunction

endpackage

// File: sv/upper_hull_insert_perimeter.sv
// top level: upper convex chain insert and perimeter sequencer
// Keeps the upper convex chain from (base_length,0) to (0,0) and its length.
// Input channel (i_valid/o_ready) carries func, point_x, point_y; output
// channel (o_valid/i_ready) returns chain_length (16 fraction bits) and status.
// One transaction is taken at a time: o_ready is high only while idle.
// A query, an ignored point or a point on the base left of its middle answers
// in the cycle after acceptance. An insert scans the stored chain from the
// right corner point by point, then evaluates each touched edge in turn;
// every edge length runs through the bit-serial square root unit.
// Each removed point costs one root, and closing the gap in the store moves
// points one at a time through its single read port.
// The result waits in the output register until i_ready; no new transaction
// is taken during that time.
// Reset: base_length 2, empty chain, length 2.0; no clearing pass is needed.
// Writing base_length over the APB port clears the chain.
module upper_hull_insert_perimeter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [15:0] i_point_x,
    input  logic [15:0] i_point_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [33:0] o_chain_length,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_ANG, S_ANG_CHK, S_POS, S_POS_B, S_POS_CR, S_POS_CHK,
        S_LEFT, S_L_CR, S_L_CHK, S_L_STEP, S_RIGHT0, S_RIGHT, S_R_CR, S_R_CHK,
        S_R_STEP, S_MOVE, S_MV_RD, S_MV_WR, S_PUT, S_OUT, S_FETCH, S_FETCH_W,
        S_CRS_M, S_CRS_R, S_E_M, S_E_R, S_E_W
    } t_state;

    typedef enum logic [1:0] {T_A, T_B, T_Q} t_tgt;

    t_state                 r_state;
    t_state                 r_ret;
    t_tgt                   r_tgt;
    logic [15:0]            r_base;
    uhi_pkg::t_cnt          r_n;
    uhi_pkg::t_len          r_len;
    uhi_pkg::t_len          r_sum;
    uhi_pkg::t_status       r_status;
    uhi_pkg::t_pt           r_p;
    uhi_pkg::t_pt           r_a;
    uhi_pkg::t_pt           r_b;
    uhi_pkg::t_pt           r_q;
    uhi_pkg::t_cnt          r_pos;
    uhi_pkg::t_cnt          r_j;
    uhi_pkg::t_cnt          r_k;
    uhi_pkg::t_cnt          r_fidx;
    uhi_pkg::t_cnt          r_cnt;
    uhi_pkg::t_cnt          r_src;
    uhi_pkg::t_cnt          r_dst;
    uhi_pkg::t_cnt          r_nn;
    logic                   r_desc;
    logic                   r_sub;
    uhi_pkg::t_diff         r_ux;
    uhi_pkg::t_diff         r_uy;
    uhi_pkg::t_diff         r_vx;
    uhi_pkg::t_diff         r_vy;
    uhi_pkg::t_cross        r_cr;

    uhi_pkg::t_coord        beff;
    uhi_pkg::t_coord        cx;
    uhi_pkg::t_coord        in_x;
    uhi_pkg::t_coord        in_y;
    uhi_pkg::t_diff         pxe;
    uhi_pkg::t_diff         axe;
    uhi_pkg::t_pt           fpt;
    uhi_pkg::t_cnt          fidx_m1;
    uhi_pkg::t_cnt          tail;
    logic                   cfg_wr;
    logic                   mem_we;
    uhi_pkg::t_addr         mem_waddr;
    uhi_pkg::t_entry        mem_wdata;
    uhi_pkg::t_addr         mem_raddr;
    uhi_pkg::t_entry        mem_rdata;
    uhi_pkg::t_cross        cross_out;
    logic                   sq_start;
    logic                   sq_busy;
    logic                   sq_done;
    logic [uhi_pkg::ITER-1:0] sq_root;

    uhi_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    uhi_cross u_cross (
        .i_clk   (i_clk),
        .i_ux    (r_ux),
        .i_uy    (r_uy),
        .i_vx    (r_vx),
        .i_vy    (r_vy),
        .o_cross (cross_out)
    );

    uhi_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (cross_out[uhi_pkg::SQ_W-1:0]),
        .o_busy     (sq_busy),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    assign cfg_wr   = psel && penable && pwrite && pready && (paddr == 3'd0);
    assign pready   = 1'b1;
    assign prdata   = (paddr == 3'd0) ? {16'd0, r_base} : 32'd0;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_chain_length = r_len;
    assign o_status = r_status;
    assign sq_start = (r_state == S_E_R);

    always_comb begin
        beff    = uhi_pkg::base_eff(r_base);
        cx      = beff >> 1;
        in_x    = uhi_pkg::t_coord'(i_point_x);
        in_y    = uhi_pkg::t_coord'(i_point_y);
        pxe     = uhi_pkg::diff(r_p.x, cx);
        if (pxe == '0 && r_p.y == '0) begin
            pxe = uhi_pkg::t_diff'(1);
        end
        axe     = uhi_pkg::diff(r_a.x, cx);
        if (axe == '0 && r_a.y == '0) begin
            axe = uhi_pkg::t_diff'(1);
        end
        fidx_m1 = r_fidx - uhi_pkg::t_cnt'(1);
        tail    = r_n + uhi_pkg::t_cnt'(1) - r_k;
        if (r_fidx == '0) begin
            fpt = '{x: beff, y: '0};
        end else if (r_fidx <= r_n) begin
            fpt = uhi_pkg::t_pt'(mem_rdata);
        end else begin
            fpt = '{x: '0, y: '0};
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_dst[uhi_pkg::ADDR_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = fidx_m1[uhi_pkg::ADDR_W-1:0];
        case (r_state)
            S_MV_RD: mem_raddr = r_src[uhi_pkg::ADDR_W-1:0];
            S_MV_WR: mem_we = 1'b1;
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_j[uhi_pkg::ADDR_W-1:0];
                mem_wdata = uhi_pkg::t_entry'(r_p);
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_base   <= 16'd2;
            r_n      <= '0;
            r_len    <= uhi_pkg::base_len(16'd2);
            r_status <= uhi_pkg::ST_QUERY;
        end else begin
            if (cfg_wr) begin
                r_base <= pwdata[15:0];
                r_n    <= '0;
                r_len  <= uhi_pkg::base_len(pwdata[15:0]);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_func) begin
                            r_status <= uhi_pkg::ST_QUERY;
                            r_state  <= S_OUT;
                        end else if (in_x == '0) begin
                            r_status <= uhi_pkg::ST_IGNORED;
                            r_state  <= S_OUT;
                        end else if (in_y == '0 && in_x < cx) begin
                            r_status <= uhi_pkg::ST_INSIDE;
                            r_state  <= S_OUT;
                        end else begin
                            r_p     <= '{x: in_x, y: in_y};
                            r_pos   <= uhi_pkg::t_cnt'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_pos <= r_n) begin
                        r_fidx  <= r_pos;
                        r_tgt   <= T_A;
                        r_ret   <= S_ANG;
                        r_state <= S_FETCH;
                    end else begin
                        r_state <= S_POS;
                    end
                end
                S_ANG: begin
                    if (r_a.y == '0 && r_a.x < cx) begin
                        r_state <= S_POS;
                    end else begin
                        r_ux    <= pxe;
                        r_uy    <= uhi_pkg::diff(r_p.y, '0);
                        r_vx    <= axe;
                        r_vy    <= uhi_pkg::diff(r_a.y, '0);
                        r_ret   <= S_ANG_CHK;
                        r_state <= S_CRS_M;
                    end
                end
                S_ANG_CHK: begin
                    if (!r_cr[uhi_pkg::CROSS_W-1] && r_cr != '0) begin
                        r_state <= S_POS;
                    end else begin
                        r_pos   <= r_pos + uhi_pkg::t_cnt'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_POS: begin
                    r_fidx  <= r_pos - uhi_pkg::t_cnt'(1);
                    r_tgt   <= T_A;
                    r_ret   <= S_POS_B;
                    r_state <= S_FETCH;
                end
                S_POS_B: begin
                    r_fidx  <= r_pos;
                    r_tgt   <= T_B;
                    r_ret   <= S_POS_CR;
                    r_state <= S_FETCH;
                end
                S_POS_CR: begin
                    r_ux    <= uhi_pkg::diff(r_b.x, r_a.x);
                    r_uy    <= uhi_pkg::diff(r_b.y, r_a.y);
                    r_vx    <= uhi_pkg::diff(r_p.x, r_a.x);
                    r_vy    <= uhi_pkg::diff(r_p.y, r_a.y);
                    r_ret   <= S_POS_CHK;
                    r_state <= S_CRS_M;
                end
                S_POS_CHK: begin
                    if (!r_cr[uhi_pkg::CROSS_W-1] && r_cr != '0) begin
                        r_status <= uhi_pkg::ST_INSIDE;
                        r_state  <= S_OUT;
                    end else if (r_n >= uhi_pkg::t_cnt'(uhi_pkg::CAPACITY)) begin
                        r_status <= uhi_pkg::ST_FULL;
                        r_state  <= S_OUT;
                    end else begin
                        r_sum   <= r_len;
                        r_j     <= r_pos - uhi_pkg::t_cnt'(1);
                        r_ux    <= uhi_pkg::diff(r_a.x, r_b.x);
                        r_uy    <= uhi_pkg::diff(r_a.y, r_b.y);
                        r_vx    <= -uhi_pkg::diff(r_a.y, r_b.y);
                        r_vy    <= uhi_pkg::diff(r_a.x, r_b.x);
                        r_sub   <= 1'b1;
                        r_ret   <= S_LEFT;
                        r_state <= S_E_M;
                    end
                end
                S_LEFT: begin
                    if (r_j != '0) begin
                        r_fidx  <= r_j - uhi_pkg::t_cnt'(1);
                        r_tgt   <= T_Q;
                        r_ret   <= S_L_CR;
                        r_state <= S_FETCH;
                    end else begin
                        r_ux    <= uhi_pkg::diff(r_a.x, r_p.x);
                        r_uy    <= uhi_pkg::diff(r_a.y, r_p.y);
                        r_vx    <= -uhi_pkg::diff(r_a.y, r_p.y);
                        r_vy    <= uhi_pkg::diff(r_a.x, r_p.x);
                        r_sub   <= 1'b0;
                        r_ret   <= S_RIGHT0;
                        r_state <= S_E_M;
                    end
                end
                S_L_CR: begin
                    r_ux    <= uhi_pkg::diff(r_a.x, r_q.x);
                    r_uy    <= uhi_pkg::diff(r_a.y, r_q.y);
                    r_vx    <= uhi_pkg::diff(r_p.x, r_q.x);
                    r_vy    <= uhi_pkg::diff(r_p.y, r_q.y);
                    r_ret   <= S_L_CHK;
                    r_state <= S_CRS_M;
                end
                S_L_CHK: begin
                    if (!r_cr[uhi_pkg::CROSS_W-1]) begin
                        r_ux  <= uhi_pkg::diff(r_a.x, r_p.x);
                        r_uy  <= uhi_pkg::diff(r_a.y, r_p.y);
                        r_vx  <= -uhi_pkg::diff(r_a.y, r_p.y);
                        r_vy  <= uhi_pkg::diff(r_a.x, r_p.x);
                        r_sub <= 1'b0;
                        r_ret <= S_RIGHT0;
                    end else begin
                        r_ux  <= uhi_pkg::diff(r_q.x, r_a.x);
                        r_uy  <= uhi_pkg::diff(r_q.y, r_a.y);
                        r_vx  <= -uhi_pkg::diff(r_q.y, r_a.y);
                        r_vy  <= uhi_pkg::diff(r_q.x, r_a.x);
                        r_sub <= 1'b1;
                        r_ret <= S_L_STEP;
                    end
                    r_state <= S_E_M;
                end
                S_L_STEP: begin
                    r_a     <= r_q;
                    r_j     <= r_j - uhi_pkg::t_cnt'(1);
                    r_state <= S_LEFT;
                end
                S_RIGHT0: begin
                    r_k     <= r_pos;
                    r_state <= S_RIGHT;
                end
                S_RIGHT: begin
                    if (r_k <= r_n) begin
                        r_fidx  <= r_k + uhi_pkg::t_cnt'(1);
                        r_tgt   <= T_Q;
                        r_ret   <= S_R_CR;
                        r_state <= S_FETCH;
                    end else begin
                        r_ux    <= uhi_pkg::diff(r_b.x, r_p.x);
                        r_uy    <= uhi_pkg::diff(r_b.y, r_p.y);
                        r_vx    <= -uhi_pkg::diff(r_b.y, r_p.y);
                        r_vy    <= uhi_pkg::diff(r_b.x, r_p.x);
                        r_sub   <= 1'b0;
                        r_ret   <= S_MOVE;
                        r_state <= S_E_M;
                    end
                end
                S_R_CR: begin
                    r_ux    <= uhi_pkg::diff(r_b.x, r_q.x);
                    r_uy    <= uhi_pkg::diff(r_b.y, r_q.y);
                    r_vx    <= uhi_pkg::diff(r_p.x, r_q.x);
                    r_vy    <= uhi_pkg::diff(r_p.y, r_q.y);
                    r_ret   <= S_R_CHK;
                    r_state <= S_CRS_M;
                end
                S_R_CHK: begin
                    if (r_cr[uhi_pkg::CROSS_W-1] || r_cr == '0) begin
                        r_ux  <= uhi_pkg::diff(r_b.x, r_p.x);
                        r_uy  <= uhi_pkg::diff(r_b.y, r_p.y);
                        r_vx  <= -uhi_pkg::diff(r_b.y, r_p.y);
                        r_vy  <= uhi_pkg::diff(r_b.x, r_p.x);
                        r_sub <= 1'b0;
                        r_ret <= S_MOVE;
                    end else begin
                        r_ux  <= uhi_pkg::diff(r_q.x, r_b.x);
                        r_uy  <= uhi_pkg::diff(r_q.y, r_b.y);
                        r_vx  <= -uhi_pkg::diff(r_q.y, r_b.y);
                        r_vy  <= uhi_pkg::diff(r_q.x, r_b.x);
                        r_sub <= 1'b1;
                        r_ret <= S_R_STEP;
                    end
                    r_state <= S_E_M;
                end
                S_R_STEP: begin
                    r_b     <= r_q;
                    r_k     <= r_k + uhi_pkg::t_cnt'(1);
                    r_state <= S_RIGHT;
                end
                S_MOVE: begin
                    r_cnt <= tail;
                    r_nn  <= r_j + uhi_pkg::t_cnt'(1) + tail;
                    if (r_j + uhi_pkg::t_cnt'(2) > r_k) begin
                        r_desc <= 1'b1;
                        r_src  <= r_n - uhi_pkg::t_cnt'(1);
                        r_dst  <= r_j + tail;
                    end else begin
                        r_desc <= 1'b0;
                        r_src  <= r_k - uhi_pkg::t_cnt'(1);
                        r_dst  <= r_j + uhi_pkg::t_cnt'(1);
                    end
                    r_state <= S_MV_RD;
                end
                S_MV_RD: begin
                    r_state <= (r_cnt == '0) ? S_PUT : S_MV_WR;
                end
                S_MV_WR: begin
                    if (r_desc) begin
                        r_src <= r_src - uhi_pkg::t_cnt'(1);
                        r_dst <= r_dst - uhi_pkg::t_cnt'(1);
                    end else begin
                        r_src <= r_src + uhi_pkg::t_cnt'(1);
                        r_dst <= r_dst + uhi_pkg::t_cnt'(1);
                    end
                    r_cnt   <= r_cnt - uhi_pkg::t_cnt'(1);
                    r_state <= S_MV_RD;
                end
                S_PUT: begin
                    r_n      <= r_nn;
                    r_len    <= r_sum;
                    r_status <= uhi_pkg::ST_ADDED;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FETCH: begin
                    r_state <= S_FETCH_W;
                end
                S_FETCH_W: begin
                    unique case (r_tgt)
                        T_A:     r_a <= fpt;
                        T_B:     r_b <= fpt;
                        default: r_q <= fpt;
                    endcase
                    r_state <= r_ret;
                end
                S_CRS_M: begin
                    r_state <= S_CRS_R;
                end
                S_CRS_R: begin
                    r_cr    <= cross_out;
                    r_state <= r_ret;
                end
                S_E_M: begin
                    r_state <= S_E_R;
                end
                S_E_R: begin
                    r_state <= S_E_W;
                end
                S_E_W: begin
                    if (sq_done) begin
                        if (r_sub) begin
                            r_sum <= r_sum - uhi_pkg::t_len'(sq_root);
                        end else begin
                            r_sum <= r_sum + uhi_pkg::t_len'(sq_root);
                        end
                        r_state <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= uhi_pkg::t_cnt'(uhi_pkg::CAPACITY))
        else $error("point count beyond capacity");

    a_sqrt_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy)
        else $error("square root started while busy");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second transaction taken while busy");

    a_added_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == uhi_pkg::ST_ADDED) |-> (r_n != '0))
        else $error("added status with empty chain");
`endif

endmodule

// File: sv/uhi_store.sv
// point store: one write port, one registered read port
module uhi_store (
    input  logic            i_clk,
    input  logic            i_we,
    input  uhi_pkg::t_addr  i_waddr,
    input  uhi_pkg::t_entry i_wdata,
    input  uhi_pkg::t_addr  i_raddr,
    output uhi_pkg::t_entry o_rdata
);

    uhi_pkg::t_entry mem [uhi_pkg::CAPACITY];
    uhi_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/uhi_cross.sv
// two-product cross unit: ux*vy - uy*vx with registered products
module uhi_cross (
    input  logic           i_clk,
    input  uhi_pkg::t_diff i_ux,
    input  uhi_pkg::t_diff i_uy,
    input  uhi_pkg::t_diff i_vx,
    input  uhi_pkg::t_diff i_vy,
    output uhi_pkg::t_cross o_cross
);

    logic signed [uhi_pkg::PROD_W-1:0] r_m1;
    logic signed [uhi_pkg::PROD_W-1:0] r_m2;

    always_ff @(posedge i_clk) begin
        r_m1 <= i_ux * i_vy;
        r_m2 <= i_uy * i_vx;
    end

    assign o_cross = uhi_pkg::t_cross'(r_m1) - uhi_pkg::t_cross'(r_m2);

endmodule

// File: sv/uhi_sqrt.sv
// bit-serial square root, one result bit per cycle, rounded to nearest
module uhi_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [uhi_pkg::SQ_W-1:0] i_radicand,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [uhi_pkg::ITER-1:0] o_root
);

    localparam int SH_W  = 2 * uhi_pkg::ITER;
    localparam int REM_W = uhi_pkg::ITER + 2;

    logic [SH_W-1:0]           r_sh;
    logic [REM_W-1:0]          r_rem;
    logic [uhi_pkg::ITER-1:0]  r_root;
    logic [uhi_pkg::ITER_W-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [REM_W-1:0]          n_rem2;
    logic [REM_W-1:0]          n_trial;
    logic [uhi_pkg::ITER:0]    n_round;

    always_comb begin
        n_rem2  = {r_rem[REM_W-3:0], r_sh[SH_W-1 -: 2]};
        n_trial = {r_root, 2'b01};
        n_round = {1'b0, r_root} + (uhi_pkg::ITER+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == uhi_pkg::ITER_W'(1));
            if (i_start) begin
                r_sh   <= SH_W'(i_radicand) << (2 * (uhi_pkg::FRAC_BITS + 1));
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= uhi_pkg::ITER_W'(uhi_pkg::ITER);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_sh <= r_sh << 2;
                if (n_rem2 >= n_trial) begin
                    r_rem  <= n_rem2 - n_trial;
                    r_root <= {r_root[uhi_pkg::ITER-2:0], 1'b1};
                end else begin
                    r_rem  <= n_rem2;
                    r_root <= {r_root[uhi_pkg::ITER-2:0], 1'b0};
                end
                r_cnt <= r_cnt - uhi_pkg::ITER_W'(1);
                if (r_cnt == uhi_pkg::ITER_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = n_round[uhi_pkg::ITER:1];

endmodule

// File: tb/testbench.sv
// self-checking testbench of the upper hull insert perimeter block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    class hull_scoreboard;
        typedef struct {
            longint x;
            longint y;
        } t_cpt;

        longint          px[uhi_pkg::CAPACITY];
        longint          py[uhi_pkg::CAPACITY];
        int unsigned     cnt;
        longint unsigned total;
        longint unsigned base;
        logic [uhi_pkg::LEN_W-1:0] exp_len[$];
        uhi_pkg::t_status          exp_st[$];
        int               errors;

        function new();
            errors = 0;
            set_base(2);
        endfunction

        function longint beff();
            return (base < 2) ? 2 : longint'(base);
        endfunction

        function void set_base(longint unsigned v);
            base  = v & 16'hffff;
            cnt   = 0;
            total = (longint'(beff()) << uhi_pkg::FRAC_BITS)
                    & ((64'd1 << uhi_pkg::LEN_W) - 1);
        endfunction

        function t_cpt at(int unsigned i);
            t_cpt p;
            p.x = 0;
            p.y = 0;
            if (i == 0) begin
                p.x = beff();
            end else if (i <= cnt) begin
                p.x = px[i-1];
                p.y = py[i-1];
            end
            return p;
        endfunction

        function longint cross3(t_cpt a, t_cpt b, t_cpt c);
            return (b.x - a.x) * (c.y - a.y) - (b.y - a.y) * (c.x - a.x);
        endfunction

        function bit left_base(t_cpt p, longint cx);
            return p.y == 0 && p.x < cx;
        endfunction

        function bit ang_gt(t_cpt a, t_cpt p, longint cx);
            longint ax, ay, qx, qy;
            ax = a.x - cx;
            ay = a.y;
            qx = p.x - cx;
            qy = p.y;
            if (left_base(a, cx)) return !left_base(p, cx);
            if (left_base(p, cx)) return 0;
            if (ax == 0 && ay == 0) ax = 1;
            if (qx == 0 && qy == 0) qx = 1;
            return qx * ay - qy * ax > 0;
        endfunction

        function longint unsigned root_fixed(longint unsigned s);
            longint unsigned rem, r, pr, tr;
            int sh;
            rem = 0;
            r = 0;
            for (int i = 26 + uhi_pkg::FRAC_BITS; i >= 0; i--) begin
                pr = 0;
                sh = 2 * (i - (uhi_pkg::FRAC_BITS + 1));
                if (sh >= 0) pr = (s >> sh) & 3;
                rem = (rem << 2) | pr;
                tr = (r << 2) | 1;
                if (rem >= tr) begin
                    rem -= tr;
                    r = (r << 1) | 1;
                end else begin
                    r = r << 1;
                end
            end
            return (r + 1) >> 1;
        endfunction

        function longint unsigned edge_len(t_cpt a, t_cpt b);
            longint dx, dy;
            dx = a.x - b.x;
            dy = a.y - b.y;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            return root_fixed(dx * dx + dy * dy);
        endfunction

        function uhi_pkg::t_status insert(longint x, longint y);
            t_cpt p;
            longint cx;
            int unsigned pos, j, k, last, tail;
            longint unsigned sum;
            longint qx[$], qy[$];
            p.x = x;
            p.y = y;
            cx = beff() / 2;
            if (x == 0) return uhi_pkg::ST_IGNORED;
            if (left_base(p, cx)) return uhi_pkg::ST_INSIDE;
            last = cnt + 1;
            pos = 1;
            while (pos < last && !ang_gt(at(pos), p, cx)) pos++;
            if (cross3(at(pos - 1), at(pos), p) > 0) return uhi_pkg::ST_INSIDE;
            if (cnt >= uhi_pkg::CAPACITY) return uhi_pkg::ST_FULL;
            sum = total - edge_len(at(pos - 1), at(pos));
            j = pos - 1;
            while (j > 0) begin
                if (cross3(at(j - 1), at(j), p) >= 0) break;
                sum -= edge_len(at(j - 1), at(j));
                j--;
            end
            sum += edge_len(at(j), p);
            k = pos;
            while (k < last) begin
                if (cross3(at(k + 1), at(k), p) <= 0) break;
                sum -= edge_len(at(k + 1), at(k));
                k++;
            end
            sum += edge_len(at(k), p);
            tail = cnt + 1 - k;
            for (int t = 0; t < tail; t++) begin
                qx.push_back(px[k - 1 + t]);
                qy.push_back(py[k - 1 + t]);
            end
            for (int t = 0; t < tail; t++) begin
                px[j + 1 + t] = qx[t];
                py[j + 1 + t] = qy[t];
            end
            px[j] = x;
            py[j] = y;
            cnt = j + 1 + tail;
            total = sum & ((64'd1 << uhi_pkg::LEN_W) - 1);
            return uhi_pkg::ST_ADDED;
        endfunction

        function void note(bit f, longint x, longint y);
            uhi_pkg::t_status st;
            st = f ? uhi_pkg::ST_QUERY : insert(x, y);
            exp_len.push_back(total[uhi_pkg::LEN_W-1:0]);
            exp_st.push_back(st);
        endfunction

        function void check(logic [uhi_pkg::LEN_W-1:0] l, logic [uhi_pkg::STAT_W-1:0] s);
            logic [uhi_pkg::LEN_W-1:0] el;
            uhi_pkg::t_status es;
            if (exp_len.size() == 0) begin
                $display("%0t: unexpected result length %0d status %0d", $time, l, s);
                errors++;
                return;
            end
            el = exp_len.pop_front();
            es = exp_st.pop_front();
            if (l !== el) begin
                $display("%0t: chain_length expected %0d actual %0d", $time, el, l);
                errors++;
            end
            if (s !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, s);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic             i_func;
    logic [15:0]      i_point_x;
    logic [15:0]      i_point_y;
    logic             o_valid;
    logic             i_ready;
    logic [33:0]      o_chain_length;
    logic [2:0]       o_status;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    hull_scoreboard sb;
    bit             send_gaps;
    bit             recv_stalls;

    localparam logic [2:0] REG_BASE = 3'd0;

    upper_hull_insert_perimeter dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("FAIL upper_hull_insert_perimeter");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note(i_func, i_point_x, i_point_y);
        if (i_rst_n && o_valid && i_ready) sb.check(o_chain_length, o_status);
    end

    initial begin
        int n;
        i_ready = 0;
        @(posedge i_rst_n);
        forever begin
            n = recv_stalls ? $urandom_range(0, 17) : 0;
            @(negedge i_clk);
            i_ready = 0;
            repeat (n) @(negedge i_clk);
            i_ready = 1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send(bit f, logic [15:0] x, logic [15:0] y);
        int n;
        n = send_gaps ? $urandom_range(0, 17) : 0;
        repeat (n) @(negedge i_clk);
        i_valid   = 1;
        i_func    = f;
        i_point_x = x;
        i_point_y = y;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic drain();
        while (sb.exp_len.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_base(logic [15:0] v);
        drain();
        psel    = 1;
        pwrite  = 1;
        paddr   = REG_BASE;
        pwdata  = {16'd0, v};
        penable = 0;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        sb.set_base(v);
        @(negedge i_clk);
        psel    = 0;
        penable = 0;
        pwrite  = 0;
    endtask

    task automatic send_arc(longint b);
        longint c, h, x, y, t;
        c = (b < 2 ? 2 : b) / 2;
        if (c == 0) c = 1;
        h = $urandom_range(1, 65535);
        x = $urandom_range(1, (b < 2 ? 2 : b));
        t = x - c;
        y = h - (t * t * h) / (c * c) + $urandom_range(0, 3);
        if (y < 0) y = $urandom_range(0, 2);
        if (y > 65535) y = 65535;
        send(0, x[15:0], y[15:0]);
    endtask

    initial begin
        longint b;
        sb        = new();
        i_rst_n   = 0;
        i_valid   = 0;
        i_func    = 0;
        i_point_x = 0;
        i_point_y = 0;
        psel      = 0;
        penable   = 0;
        pwrite    = 0;
        paddr     = REG_BASE;
        pwdata    = 0;
        send_gaps = 1;
        recv_stalls = 1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed corners at reset base, wide base and bases 0, 1 and 2
        send(1, 0, 0);
        send(0, 1, 1);
        send(0, 0, 5);
        write_base(16'hffff);
        send(0, 100, 0);
        send(0, 32767, 0);
        send(0, 60000, 0);
        send(0, 65535, 65535);
        send(0, 1, 65535);
        send(0, 30000, 65535);
        send(0, 30000, 100);
        send(0, 65535, 0);
        send(0, 16'hffff, 16'hffff);
        send(1, 16'hffff, 16'hffff);
        write_base(16'd0);
        send(0, 1, 0);
        send(0, 2, 3);
        send(0, 1, 3);
        write_base(16'd1);
        send(0, 3, 3);
        send(1, 0, 0);
        write_base(16'd2);
        send(0, 1, 1);
        send(0, 2, 1);

        // collinear points fill the store, then overflow it
        write_base(16'hffff);
        send_gaps = 0;
        recv_stalls = 0;
        for (int i = 0; i < uhi_pkg::CAPACITY + 2; i++) send(0, 16'(100 + i), 16'd30000);
        send(1, 0, 0);
        send_gaps = 1;
        recv_stalls = 1;

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: b = 65535;
                1: b = 2;
                2: b = 3;
                3: b = 0;
                default: b = $urandom_range(2, 65535);
            endcase
            write_base(b[15:0]);
            send_gaps   = (ph % 3) != 2;
            recv_stalls = (ph % 4) != 3;
            for (int i = 0; i < 70; i++) begin
                if (i == 35) drain();
                case ($urandom_range(0, 9))
                    0: send(1, 16'($urandom), 16'($urandom));
                    1, 2: send(0, 16'($urandom), 16'($urandom));
                    default: send_arc(b);
                endcase
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("PASS upper_hull_insert_perimeter");
        end else begin
            $display("FAIL upper_hull_insert_perimeter");
        end
        $finish;
    end
endmodule
